// ===== sv/mec_pkg.sv =====
// mec_pkg: shared types, register indexes and defaults for the morse element classifier
// no dependencies; imported by every module of the block

package mec_pkg;

    // default widths and queue depth
    localparam int TIME_WIDTH_DEFAULT     = 20;
    localparam int DEBOUNCE_WIDTH_DEFAULT = 16;
    localparam int QUEUE_DEPTH_DEFAULT    = 2;

    // configuration register indexes
    localparam int CFG_INDEX_WIDTH = 3;
    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

    localparam cfg_index_t REG_FLIP_UP_COUNT          = 3'd0;
    localparam cfg_index_t REG_FLIP_DOWN_COUNT        = 3'd1;
    localparam cfg_index_t REG_MIN_DIT_SAMPLES        = 3'd2;
    localparam cfg_index_t REG_MIN_DAH_SAMPLES        = 3'd3;
    localparam cfg_index_t REG_MIN_WORD_SPACE_SAMPLES = 3'd4;
    localparam cfg_index_t REG_MIN_LETTER_SEP_SAMPLES = 3'd5;
    localparam cfg_index_t REG_MAX_RUN_SAMPLES        = 3'd6;

    // output symbol codes
    localparam int SYMBOL_WIDTH = 2;

    typedef enum logic [SYMBOL_WIDTH-1:0] {
        SYM_DAH        = 2'd0,
        SYM_DIT        = 2'd1,
        SYM_WORD_SPACE = 2'd2,
        SYM_LETTER_SEP = 2'd3
    } symbol_t;

    // front to queue: one classified item
    typedef struct packed {
        logic    valid;
        symbol_t sym;
    } sym_push_t;

    // queue occupancy flags
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== sv/morse_element_classifier.sv =====
// morse_element_classifier: key-level samples in, dit/dah/space symbols out
// depends on mec_pkg, mec_front, mec_queue, mec_back
//
// Usage:
//   Input channel (in_valid / in_stall / key_level) takes one key sample per item.
//   Result channel (out_valid / out_stall / symbol) gives 0 dah, 1 dit,
//   2 word space, 3 letter separator; a sample gives at most one symbol.
//   Registers are written through wr_en / wr_index / wr_data while idle;
//   index 0..6 as in mec_pkg, other indexes are ignored.
// Timing:
//   One sample per cycle while in_stall is low. The front debounces and classifies a sample
//   in the cycle it is accepted and writes its symbol into a two-entry queue;
//   the output register takes it from the queue when that register is empty or
//   being taken, and out_valid then shows the symbol until it is taken.
// Reset:
//   Key up, counters and run timer zero, thresholds zero, max run all ones.
// Backpressure:
//   A stalled symbol holds in the output register; further symbols fill the
//   queue, and in_stall rises only when the queue is full.

module morse_element_classifier
    import mec_pkg::*;
#(
    parameter int TIME_WIDTH     = TIME_WIDTH_DEFAULT,
    parameter int DEBOUNCE_WIDTH = DEBOUNCE_WIDTH_DEFAULT,
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEFAULT,
    parameter int DATA_WIDTH     = (TIME_WIDTH > DEBOUNCE_WIDTH) ? TIME_WIDTH : DEBOUNCE_WIDTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] wr_index,
    input  logic [DATA_WIDTH-1:0]   wr_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    key_level,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [SYMBOL_WIDTH-1:0] symbol
);

    sym_push_t push;
    q_status_t status;
    symbol_t   head;
    logic      pop;
    logic      accept;

    // input taken whenever the queue has room
    assign in_stall = status.full;
    assign accept   = in_valid & ~in_stall;

    mec_front #(
        .TIME_WIDTH     (TIME_WIDTH),
        .DEBOUNCE_WIDTH (DEBOUNCE_WIDTH),
        .DATA_WIDTH     (DATA_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .accept    (accept),
        .key_level (key_level),
        .push      (push)
    );

    mec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .status (status),
        .head   (head)
    );

    mec_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (status),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .symbol    (symbol)
    );

endmodule

// ===== sv/mec_front.sv =====
// mec_front: configuration registers, integrating key debouncer, run timer and classifier
// depends on mec_pkg

module mec_front
    import mec_pkg::*;
#(
    parameter int TIME_WIDTH     = TIME_WIDTH_DEFAULT,
    parameter int DEBOUNCE_WIDTH = DEBOUNCE_WIDTH_DEFAULT,
    parameter int DATA_WIDTH     = (TIME_WIDTH > DEBOUNCE_WIDTH) ? TIME_WIDTH : DEBOUNCE_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  cfg_index_t            wr_index,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic                  accept,
    input  logic                  key_level,
    output sym_push_t             push
);

    localparam int RUN_WIDTH = TIME_WIDTH + 1;

    logic [DEBOUNCE_WIDTH-1:0] flip_up_reg;
    logic [DEBOUNCE_WIDTH-1:0] flip_down_reg;
    logic [TIME_WIDTH-1:0]     min_dit_reg;
    logic [TIME_WIDTH-1:0]     min_dah_reg;
    logic [TIME_WIDTH-1:0]     min_word_reg;
    logic [TIME_WIDTH-1:0]     min_sep_reg;
    logic [TIME_WIDTH-1:0]     max_run_reg;

    logic                      key_down_reg;
    logic                      key_down_next;
    logic [DEBOUNCE_WIDTH-1:0] deb_count_reg;
    logic [DEBOUNCE_WIDTH-1:0] deb_count_next;
    logic [RUN_WIDTH-1:0]      run_reg;
    logic [RUN_WIDTH-1:0]      run_next;

    logic [DEBOUNCE_WIDTH-1:0] deb_step;
    logic [DEBOUNCE_WIDTH-1:0] deb_threshold;
    logic                      count_up;
    logic                      flip;
    logic                      emit;
    symbol_t                   emit_sym;

    // configuration writes, low bits kept, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_up_reg   <= '0;
            flip_down_reg <= '0;
            min_dit_reg   <= '0;
            min_dah_reg   <= '0;
            min_word_reg  <= '0;
            min_sep_reg   <= '0;
            max_run_reg   <= '1;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_FLIP_UP_COUNT:          flip_up_reg   <= wr_data[DEBOUNCE_WIDTH-1:0];
                REG_FLIP_DOWN_COUNT:        flip_down_reg <= wr_data[DEBOUNCE_WIDTH-1:0];
                REG_MIN_DIT_SAMPLES:        min_dit_reg   <= wr_data[TIME_WIDTH-1:0];
                REG_MIN_DAH_SAMPLES:        min_dah_reg   <= wr_data[TIME_WIDTH-1:0];
                REG_MIN_WORD_SPACE_SAMPLES: min_word_reg  <= wr_data[TIME_WIDTH-1:0];
                REG_MIN_LETTER_SEP_SAMPLES: min_sep_reg   <= wr_data[TIME_WIDTH-1:0];
                REG_MAX_RUN_SAMPLES:        max_run_reg   <= wr_data[TIME_WIDTH-1:0];
                default:                    ;
            endcase
        end
    end

    // integrating debouncer: the idle-side counter is always zero, so one counter serves both
    always_comb
    begin
        count_up = key_level ^ key_down_reg;
        if (count_up)
            deb_step = (&deb_count_reg) ? deb_count_reg : deb_count_reg + 1'b1;
        else
            deb_step = (deb_count_reg != '0) ? deb_count_reg - 1'b1 : deb_count_reg;
        deb_threshold  = key_down_reg ? flip_down_reg : flip_up_reg;
        flip           = (deb_step >= deb_threshold);
        deb_count_next = flip ? '0 : deb_step;
        key_down_next  = flip ? ~key_down_reg : key_down_reg;
    end

    // run classification and run timer
    always_comb
    begin
        emit     = 1'b0;
        emit_sym = SYM_WORD_SPACE;
        if (flip)
        begin
            run_next = '0;
            if (key_down_reg)
            begin
                if (run_reg > {1'b0, min_dah_reg})
                begin
                    emit     = 1'b1;
                    emit_sym = SYM_DAH;
                end
                else if (run_reg > {1'b0, min_dit_reg})
                begin
                    emit     = 1'b1;
                    emit_sym = SYM_DIT;
                end
            end
            else
            begin
                if (run_reg >= {1'b0, min_word_reg})
                begin
                    emit     = 1'b1;
                    emit_sym = SYM_WORD_SPACE;
                end
                else if (run_reg >= {1'b0, min_sep_reg})
                begin
                    emit     = 1'b1;
                    emit_sym = SYM_LETTER_SEP;
                end
            end
        end
        else if (run_reg > {1'b0, max_run_reg})
        begin
            // overlong run: word space and restart, timer counts this sample
            emit     = 1'b1;
            emit_sym = SYM_WORD_SPACE;
            run_next = RUN_WIDTH'(1);
        end
        else
        begin
            run_next = (&run_reg) ? run_reg : run_reg + 1'b1;
        end
    end

    assign push.valid = accept & emit;
    assign push.sym   = emit_sym;

    // key state, advanced once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_down_reg  <= 1'b0;
            deb_count_reg <= '0;
            run_reg       <= '0;
        end
        else if (accept)
        begin
            key_down_reg  <= key_down_next;
            deb_count_reg <= deb_count_next;
            run_reg       <= run_next;
        end
    end

endmodule

// ===== sv/mec_queue.sv =====
// mec_queue: short symbol queue between the classifier and the output stage
// depends on mec_pkg

module mec_queue
    import mec_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  sym_push_t push,
    input  logic      pop,
    output q_status_t status,
    output symbol_t   head
);

    localparam int PTR_WIDTH   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

    symbol_t                entry_reg [DEPTH];
    logic [PTR_WIDTH-1:0]   wr_ptr_reg;
    logic [PTR_WIDTH-1:0]   rd_ptr_reg;
    logic [COUNT_WIDTH-1:0] count_reg;

    assign status.full  = (count_reg == COUNT_WIDTH'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push.valid)
            entry_reg[wr_ptr_reg] <= push.sym;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= (wr_ptr_reg == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            case ({push.valid, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== sv/mec_back.sv =====
// mec_back: output register that drains the symbol queue onto the result channel
// depends on mec_pkg

module mec_back
    import mec_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  q_status_t               status,
    input  symbol_t                 head,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [SYMBOL_WIDTH-1:0] symbol
);

    logic    out_valid_reg;
    logic    out_valid_next;
    symbol_t symbol_reg;

    // refill whenever the register is empty or being taken
    assign pop            = ~status.empty & (~out_valid_reg | ~out_stall);
    assign out_valid_next = pop | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            symbol_reg <= head;
    end

    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;

endmodule

// ===== sv/mec_checker.sv =====
// mec_checker: port-level assertions for the morse element classifier, bound to the top level
// depends on mec_pkg and morse_element_classifier

module mec_checker
    import mec_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [SYMBOL_WIDTH-1:0] symbol
);

    // a stalled symbol stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(symbol))
    else $error("stalled symbol changed or dropped");

    // first cycle out of reset: nothing pending, input open
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !in_stall && !out_valid)
    else $error("block not empty after reset");

    // a fresh symbol follows an accepted item through the queue and the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("symbol appeared without an accepted item");

    // input is held off only while the output register is occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
    else $error("input stalled with empty output register");

endmodule

bind morse_element_classifier mec_checker u_mec_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .symbol    (symbol)
);
